@@ hw/rtl/pia_pkg.sv @@
// ----------------------------------------------------------------------------
// pia_pkg
// types and constants shared by the parallel interface adapter
// ----------------------------------------------------------------------------
package pia_pkg;

    typedef enum logic [2:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_CA1   = 3'd2,
        OP_CA2   = 3'd3,
        OP_CB1   = 3'd4,
        OP_CB2   = 3'd5
    } pia_op_t;

    localparam int unsigned CR_IRQ1   = 7;
    localparam int unsigned CR_IRQ2   = 6;
    localparam int unsigned CR_C2OUT  = 5;
    localparam int unsigned CR_B4     = 4;
    localparam int unsigned CR_B3     = 3;
    localparam int unsigned CR_DATA   = 2;
    localparam int unsigned CR_C1RISE = 1;
    localparam int unsigned CR_C1EN   = 0;

    typedef struct packed {
        logic       rd;
        logic       wr;
        logic       c1_ev;
        logic       c2_ev;
        logic       ctrl_sel;
        logic       strobe_on_read;
        logic       strobe_on_write;
        logic [7:0] wdata;
        logic       lvl;
        logic [7:0] pins;
    } pia_side_cmd_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq;
        logic [7:0] data;
        logic       strobe;
        logic       c2;
    } pia_side_stat_t;

endpackage

@@ hw/rtl/pia_intf.sv @@
// ----------------------------------------------------------------------------
// pia_intf
// request and result channels of the parallel interface adapter
// ----------------------------------------------------------------------------
interface pia_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [1:0] reg_select;
    logic [7:0] write_data;
    logic       line_level;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;

    modport source (
        output valid, op, reg_select, write_data, line_level, port_a_pins, port_b_pins,
        input  ready
    );
    modport sink (
        input  valid, op, reg_select, write_data, line_level, port_a_pins, port_b_pins,
        output ready
    );
endinterface

interface pia_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_a;
    logic       irq_b;
    logic [7:0] port_a_out;
    logic [7:0] port_b_out;
    logic       port_a_strobe;
    logic       port_b_strobe;
    logic       ca2_out;
    logic       cb2_out;

    modport source (
        output valid, read_data, irq_a, irq_b, port_a_out, port_b_out,
               port_a_strobe, port_b_strobe, ca2_out, cb2_out,
        input  ready
    );
    modport sink (
        input  valid, read_data, irq_a, irq_b, port_a_out, port_b_out,
               port_a_strobe, port_b_strobe, ca2_out, cb2_out,
        output ready
    );
endinterface

@@ hw/rtl/pia_side.sv @@
// ----------------------------------------------------------------------------
// pia_side
// registers and update logic of one adapter side (control, direction, data,
// control line levels)
// ----------------------------------------------------------------------------
module pia_side (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  pia_pkg::pia_side_cmd_t  cmd,
    output pia_pkg::pia_side_stat_t stat
);

    logic [7:0] control_reg, control_next;
    logic [7:0] direction_reg, direction_next;
    logic [7:0] data_reg, data_next;
    logic       c1_reg, c1_next;
    logic       c2_reg, c2_next;
    logic [7:0] rdata;
    logic       strobe;
    logic       c1_active;
    logic       c2_active;
    logic       strobe_mode;

    assign strobe_mode = control_reg[pia_pkg::CR_C2OUT] & ~control_reg[pia_pkg::CR_B4];
    assign c1_active   = control_reg[pia_pkg::CR_C1RISE] ? (~c1_reg & cmd.lvl)
                                                         : (c1_reg & ~cmd.lvl);
    assign c2_active   = control_reg[pia_pkg::CR_B4] ? (~c2_reg & cmd.lvl)
                                                     : (c2_reg & ~cmd.lvl);

    always_comb
    begin
        control_next   = control_reg;
        direction_next = direction_reg;
        data_next      = data_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        rdata          = 8'h00;
        strobe         = 1'b0;
        if (cmd.rd)
        begin
            if (cmd.ctrl_sel)
            begin
                rdata = control_reg;
            end
            else if (!control_reg[pia_pkg::CR_DATA])
            begin
                rdata = direction_reg;
            end
            else
            begin
                if (cmd.strobe_on_read && strobe_mode)
                begin
                    c2_next = control_reg[pia_pkg::CR_B3];
                end
                control_next[pia_pkg::CR_IRQ1] = 1'b0;
                control_next[pia_pkg::CR_IRQ2] = 1'b0;
                rdata = (data_reg & direction_reg) | (cmd.pins & ~direction_reg);
            end
        end
        else if (cmd.wr)
        begin
            if (cmd.ctrl_sel)
            begin
                control_next = {control_reg[7:6], cmd.wdata[5:0]};
                if (cmd.wdata[pia_pkg::CR_C2OUT] && cmd.wdata[pia_pkg::CR_B4])
                begin
                    c2_next = cmd.wdata[pia_pkg::CR_B3];
                end
            end
            else if (!control_reg[pia_pkg::CR_DATA])
            begin
                direction_next = cmd.wdata;
            end
            else
            begin
                if (cmd.strobe_on_write && strobe_mode)
                begin
                    c2_next = control_reg[pia_pkg::CR_B3];
                end
                strobe    = 1'b1;
                data_next = cmd.wdata;
            end
        end
        else if (cmd.c1_ev)
        begin
            if (c1_active)
            begin
                if (control_reg[pia_pkg::CR_C1EN])
                begin
                    control_next[pia_pkg::CR_IRQ1] = 1'b1;
                end
                // handshake mode: active c1 edge restores c2
                if (control_reg[5:3] == 3'b100)
                begin
                    c2_next = 1'b1;
                end
            end
            c1_next = cmd.lvl;
        end
        else if (cmd.c2_ev)
        begin
            if (!control_reg[pia_pkg::CR_C2OUT])
            begin
                if (c2_active && control_reg[pia_pkg::CR_B3])
                begin
                    control_next[pia_pkg::CR_IRQ2] = 1'b1;
                end
                c2_next = cmd.lvl;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg   <= 8'h00;
            direction_reg <= 8'h00;
            data_reg      <= 8'h00;
            c1_reg        <= 1'b0;
            c2_reg        <= 1'b0;
        end
        else if (advance)
        begin
            control_reg   <= control_next;
            direction_reg <= direction_next;
            data_reg      <= data_next;
            c1_reg        <= c1_next;
            c2_reg        <= c2_next;
        end
    end

    assign stat.rdata  = rdata;
    assign stat.irq    = control_next[pia_pkg::CR_IRQ1] | control_next[pia_pkg::CR_IRQ2];
    assign stat.data   = data_next;
    assign stat.strobe = strobe;
    assign stat.c2     = c2_next;

endmodule

@@ hw/rtl/peripheral_interface_adapter.sv @@
// ----------------------------------------------------------------------------
// peripheral_interface_adapter
// two-port parallel interface adapter with control lines ca1/ca2/cb1/cb2
//
// request channel: one bus read, bus write (reg_select picks data/direction
// or control of side a or b) or a new level on one of the control lines
// result channel: one result per request with read data, both interrupt
// lines, port output registers, write strobes and ca2/cb2 levels
// path: the input register loads at the accept edge, and the update logic
// feeds the result register, which loads once it is free or being taken;
// the result is then offered on the result channel until it is taken
// throughput: one request per cycle unless the result is held; the side
// registers load with the result register, so the next request sees them
// reset: all control, direction, data and line level registers clear, both
// pipeline stages empty
// stall: a held result keeps the result register; one more request is taken
// into the input register and then the request channel stalls
// ----------------------------------------------------------------------------
module peripheral_interface_adapter (
    input  logic            clk,
    input  logic            rst_n,
    pia_req_if.sink         request,
    pia_rsp_if.source       result
);

    logic       in_valid_reg;
    logic [2:0] op_reg;
    logic [1:0] rs_reg;
    logic [7:0] wdata_reg;
    logic       lvl_reg;
    logic [7:0] pins_a_reg;
    logic [7:0] pins_b_reg;

    logic       out_valid_reg;
    logic [7:0] read_data_reg;
    logic       irq_a_reg;
    logic       irq_b_reg;
    logic [7:0] port_a_out_reg;
    logic [7:0] port_b_out_reg;
    logic       strobe_a_reg;
    logic       strobe_b_reg;
    logic       ca2_reg;
    logic       cb2_reg;

    logic       advance;
    logic       is_read;
    logic       is_write;

    pia_pkg::pia_side_cmd_t  cmd_a;
    pia_pkg::pia_side_cmd_t  cmd_b;
    pia_pkg::pia_side_stat_t stat_a;
    pia_pkg::pia_side_stat_t stat_b;

    assign advance       = in_valid_reg & (~out_valid_reg | result.ready);
    assign request.ready = ~in_valid_reg | advance;

    assign is_read  = (op_reg == pia_pkg::OP_READ);
    assign is_write = (op_reg == pia_pkg::OP_WRITE);

    always_comb
    begin
        cmd_a.rd              = is_read & ~rs_reg[1];
        cmd_a.wr              = is_write & ~rs_reg[1];
        cmd_a.c1_ev           = (op_reg == pia_pkg::OP_CA1);
        cmd_a.c2_ev           = (op_reg == pia_pkg::OP_CA2);
        cmd_a.ctrl_sel        = rs_reg[0];
        cmd_a.strobe_on_read  = 1'b1;
        cmd_a.strobe_on_write = 1'b0;
        cmd_a.wdata           = wdata_reg;
        cmd_a.lvl             = lvl_reg;
        cmd_a.pins            = pins_a_reg;

        cmd_b.rd              = is_read & rs_reg[1];
        cmd_b.wr              = is_write & rs_reg[1];
        cmd_b.c1_ev           = (op_reg == pia_pkg::OP_CB1);
        cmd_b.c2_ev           = (op_reg == pia_pkg::OP_CB2);
        cmd_b.ctrl_sel        = rs_reg[0];
        cmd_b.strobe_on_read  = 1'b0;
        cmd_b.strobe_on_write = 1'b1;
        cmd_b.wdata           = wdata_reg;
        cmd_b.lvl             = lvl_reg;
        cmd_b.pins            = pins_b_reg;
    end

    pia_side u_side_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cmd     (cmd_a),
        .stat    (stat_a)
    );

    pia_side u_side_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cmd     (cmd_b),
        .stat    (stat_b)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (request.ready)
        begin
            in_valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.ready && request.valid)
        begin
            op_reg     <= request.op;
            rs_reg     <= request.reg_select;
            wdata_reg  <= request.write_data;
            lvl_reg    <= request.line_level;
            pins_a_reg <= request.port_a_pins;
            pins_b_reg <= request.port_b_pins;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_data_reg  <= stat_a.rdata | stat_b.rdata;
            irq_a_reg      <= stat_a.irq;
            irq_b_reg      <= stat_b.irq;
            port_a_out_reg <= stat_a.data;
            port_b_out_reg <= stat_b.data;
            strobe_a_reg   <= stat_a.strobe;
            strobe_b_reg   <= stat_b.strobe;
            ca2_reg        <= stat_a.c2;
            cb2_reg        <= stat_b.c2;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.read_data     = read_data_reg;
    assign result.irq_a         = irq_a_reg;
    assign result.irq_b         = irq_b_reg;
    assign result.port_a_out    = port_a_out_reg;
    assign result.port_b_out    = port_b_out_reg;
    assign result.port_a_strobe = strobe_a_reg;
    assign result.port_b_strobe = strobe_b_reg;
    assign result.ca2_out       = ca2_reg;
    assign result.cb2_out       = cb2_reg;

endmodule
